// File: sv/ebd_pkg.sv
// ----------------------------------------------------------------------------
// ebd_pkg
// Types, widths and register reset values shared by the beat detector.
// ----------------------------------------------------------------------------
package ebd_pkg;

  localparam int E_W      = 16;   // frame energy, Q0.16
  localparam int HLEN_W   = 7;
  localparam int SENS_W   = 12;   // Q4.8
  localparam int GAP_W    = 8;
  localparam int SUM_W    = 22;
  localparam int MEAN_SH  = 8;    // weight of count*energy against Q4.8 factor

  localparam logic [GAP_W-1:0]  GAP_SAT = 8'd255;

  localparam logic [HLEN_W-1:0] HLEN_RST  = 7'd32;
  localparam logic [SENS_W-1:0] SENS_RST  = 12'd384;
  localparam logic [GAP_W-1:0]  MINGAP_RST = 8'd15;
  localparam logic [E_W-1:0]    FLOOR_RST = 16'd6554;

  typedef enum logic [1:0] {
    REG_HISTORY_LEN = 2'd0,
    REG_SENSITIVITY = 2'd1,
    REG_MIN_GAP     = 2'd2,
    REG_FLOOR_LEVEL = 2'd3
  } cfg_reg_e;

  // control broadcast along the row of ring cells
  typedef struct packed {
    logic step;      // item accepted, write slot and move token
    logic prewrap;   // pointer lies beyond the history length, slot is cell 0
    logic wrap;      // token returns to cell 0 after this item
  } ring_ctrl_t;

endpackage

// File: sv/energy_beat_detector_unit.sv
// ----------------------------------------------------------------------------
// energy_beat_detector_unit
// Energy beat detector: running mean over a ring of recent frame energies.
// ----------------------------------------------------------------------------
// Pipeline: the sum is updated on accept, then stages B, M (products) and O
// (compare and gap count); one item per cycle unless a stall holds the flow.
// The ring row prefetches the slot to evict into a register; after a change of
// history_len the first item may stall until that prefetch is taken anew.
// Reset: registers return to defaults, pointer, count and sum clear, the gap
// count saturates; ring contents are not cleared.
// ----------------------------------------------------------------------------
module energy_beat_detector_unit
  import ebd_pkg::*;
#(
  parameter int HISTORY_MAX = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // input items
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [E_W-1:0]   energy_i,
  // result items
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             beat_o,
  output logic [GAP_W-1:0] gap_count_o
);

  localparam int PTR_W  = $clog2(HISTORY_MAX);
  localparam int LEN_W  = $clog2(HISTORY_MAX + 1);
  localparam int CMP_W  = (LEN_W > HLEN_W) ? LEN_W : HLEN_W;
  localparam int PROD_W = E_W + LEN_W;
  localparam int LHS_W  = PROD_W + MEAN_SH;
  localparam int RHS_W  = SENS_W + SUM_W;
  localparam int MUL_W  = (LHS_W > RHS_W) ? LHS_W : RHS_W;

  // ---------------- configuration registers ----------------
  logic [HLEN_W-1:0] hist_len_q;
  logic [SENS_W-1:0] sens_q;
  logic [GAP_W-1:0]  min_gap_q;
  logic [E_W-1:0]    floor_q;
  logic              cfg_wr;
  cfg_reg_e          cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = cfg_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_len_q <= HLEN_RST;
      sens_q     <= SENS_RST;
      min_gap_q  <= MINGAP_RST;
      floor_q    <= FLOOR_RST;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_HISTORY_LEN: hist_len_q <= pwdata[HLEN_W-1:0];
        REG_SENSITIVITY: sens_q     <= pwdata[SENS_W-1:0];
        REG_MIN_GAP:     min_gap_q  <= pwdata[GAP_W-1:0];
        REG_FLOOR_LEVEL: floor_q    <= pwdata[E_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_HISTORY_LEN: prdata = 32'(hist_len_q);
      REG_SENSITIVITY: prdata = 32'(sens_q);
      REG_MIN_GAP:     prdata = 32'(min_gap_q);
      REG_FLOOR_LEVEL: prdata = 32'(floor_q);
    endcase
  end

  // ---------------- effective length and ring pointer ----------------
  logic [LEN_W-1:0] len;
  logic [CMP_W-1:0] hl_ext;
  logic [PTR_W-1:0] ptr_q, slot, nxt, pf_ptr_q;
  logic [LEN_W-1:0] slot_inc;
  logic             prewrap, wrap, pf_miss, accept;

  always_comb begin
    hl_ext = CMP_W'(hist_len_q);
    if (hl_ext == '0) begin
      len = LEN_W'(1);
    end else if (hl_ext > CMP_W'(HISTORY_MAX)) begin
      len = LEN_W'(HISTORY_MAX);
    end else begin
      len = LEN_W'(hl_ext);
    end
  end

  assign prewrap  = LEN_W'(ptr_q) >= len;
  assign slot     = prewrap ? '0 : ptr_q;
  assign slot_inc = LEN_W'(slot) + LEN_W'(1);
  assign wrap     = slot_inc == len;
  assign nxt      = wrap ? '0 : PTR_W'(slot_inc);
  // evict prefetch was taken for another slot (length just changed)
  assign pf_miss  = pf_ptr_q != slot;

  // ---------------- pipeline handshake ----------------
  logic v_b_q, v_m_q, v_o_q;
  logic en_b, en_m, en_o;

  assign en_o       = !v_o_q || !out_stall_i;
  assign en_m       = !v_m_q || en_o;
  assign en_b       = !v_b_q || en_m;
  assign in_stall_o = !en_b || pf_miss;
  assign accept     = in_valid_i && !in_stall_o;

  // ---------------- ring of cells ----------------
  ring_ctrl_t             ring_ctrl;
  logic [E_W-1:0]         evict;
  logic [HISTORY_MAX-1:0] tok_vec;

  assign ring_ctrl.step    = accept;
  assign ring_ctrl.prewrap = prewrap;
  assign ring_ctrl.wrap    = wrap;

  ebd_ring #(
    .DEPTH (HISTORY_MAX)
  ) u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ring_ctrl),
    .data_i  (energy_i),
    .evict_o (evict),
    .tok_o   (tok_vec)
  );

  // ---------------- running sum and fill count ----------------
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [LEN_W-1:0] fill_q, fill_d;

  always_comb begin
    if (fill_q < len) begin
      sum_d  = sum_q + SUM_W'(energy_i);
      fill_d = fill_q + LEN_W'(1);
    end else begin
      sum_d  = sum_q - SUM_W'(evict) + SUM_W'(energy_i);
      fill_d = fill_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q    <= '0;
      pf_ptr_q <= '0;
      sum_q    <= '0;
      fill_q   <= '0;
    end else begin
      pf_ptr_q <= accept ? nxt : slot;
      if (accept) begin
        ptr_q  <= nxt;
        sum_q  <= sum_d;
        fill_q <= fill_d;
      end
    end
  end

  // ---------------- stage B: snapshot of the updated state ----------------
  logic [E_W-1:0]   e_b_q;
  logic [LEN_W-1:0] fill_b_q;
  logic [SUM_W-1:0] sum_b_q;
  logic             floor_b_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      e_b_q     <= energy_i;
      fill_b_q  <= fill_d;
      sum_b_q   <= sum_d;
      floor_b_q <= energy_i > floor_q;
    end
  end

  // ---------------- stage M: products ----------------
  logic [PROD_W-1:0] prod_m_q;
  logic [RHS_W-1:0]  rhs_m_q;
  logic              floor_m_q;

  always_ff @(posedge clk_i) begin
    if (en_m && v_b_q) begin
      prod_m_q  <= PROD_W'(e_b_q) * PROD_W'(fill_b_q);
      rhs_m_q   <= RHS_W'(sens_q) * RHS_W'(sum_b_q);
      floor_m_q <= floor_b_q;
    end
  end

  // ---------------- stage O: compare, gap count, result ----------------
  logic [GAP_W-1:0] since_q, gap;
  logic [MUL_W-1:0] lhs_ext, rhs_ext;
  logic             beat_d, beat_q;
  logic [GAP_W-1:0] gap_q;

  assign lhs_ext = MUL_W'({prod_m_q, {MEAN_SH{1'b0}}});
  assign rhs_ext = MUL_W'(rhs_m_q);
  assign gap     = (since_q == GAP_SAT) ? GAP_SAT : since_q + GAP_W'(1);
  assign beat_d  = floor_m_q && (lhs_ext > rhs_ext) && (gap >= min_gap_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_b_q   <= 1'b0;
      v_m_q   <= 1'b0;
      v_o_q   <= 1'b0;
      since_q <= GAP_SAT;
    end else begin
      if (en_b) begin
        v_b_q <= accept;
      end
      if (en_m) begin
        v_m_q <= v_b_q;
      end
      if (en_o) begin
        v_o_q <= v_m_q;
      end
      if (en_o && v_m_q) begin
        since_q <= beat_d ? '0 : gap;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o && v_m_q) begin
      beat_q <= beat_d;
      gap_q  <= gap;
    end
  end

  assign out_valid_o = v_o_q;
  assign beat_o      = beat_q;
  assign gap_count_o = gap_q;

  // ---------------- assertions ----------------
  a_tok_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(tok_vec) && tok_vec[ptr_q])
    else $error("ring token does not match pointer");

  a_full_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_b_q && v_m_q && v_o_q && out_stall_i) |-> in_stall_o)
    else $error("item accepted into a full pipeline");

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (fill_q != '0) && (fill_q <= LEN_W'(HISTORY_MAX)))
    else $error("fill count out of range after an item");

endmodule

// File: sv/ebd_cell.sv
// ----------------------------------------------------------------------------
// ebd_cell
// One ring slot: holds a stored energy and the write token, hands the token
// to its right neighbor on each accepted item, or back to cell 0 on a wrap.
// ----------------------------------------------------------------------------
module ebd_cell
  import ebd_pkg::*;
#(
  parameter bit HOME = 1'b0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ring_ctrl_t     ctrl_i,
  input  logic           tok_prev_i,
  input  logic [E_W-1:0] data_i,
  output logic           tok_eff_o,
  output logic           tok_o,
  output logic [E_W-1:0] rd_o
);

  logic           tok_q, tok_d;
  logic [E_W-1:0] val_q;
  logic           wr, sel_next;

  assign tok_eff_o = ctrl_i.prewrap ? HOME : tok_q;
  assign tok_o     = tok_q;
  assign tok_d     = HOME ? ctrl_i.wrap : (tok_prev_i && !ctrl_i.wrap);
  assign wr        = ctrl_i.step && tok_eff_o;
  assign sel_next  = ctrl_i.step ? tok_d : tok_eff_o;
  // value of the slot the next item will use, with write forwarding
  assign rd_o      = sel_next ? (wr ? data_i : val_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= HOME;
    end else if (ctrl_i.step) begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      val_q <= data_i;
    end
  end

endmodule

// File: sv/ebd_ring.sv
// ----------------------------------------------------------------------------
// ebd_ring
// Row of ring cells with a registered read of the slot due for eviction.
// ----------------------------------------------------------------------------
module ebd_ring
  import ebd_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ring_ctrl_t       ctrl_i,
  input  logic [E_W-1:0]   data_i,
  output logic [E_W-1:0]   evict_o,
  output logic [DEPTH-1:0] tok_o
);

  logic [DEPTH-1:0]          tok_eff;
  logic [DEPTH-1:0][E_W-1:0] rd;
  logic [E_W-1:0]            evict_d, evict_q;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic tok_prev;
    if (k == 0) begin : g_first
      assign tok_prev = 1'b0;
    end else begin : g_rest
      assign tok_prev = tok_eff[k-1];
    end
    ebd_cell #(
      .HOME (k == 0)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl_i),
      .tok_prev_i (tok_prev),
      .data_i     (data_i),
      .tok_eff_o  (tok_eff[k]),
      .tok_o      (tok_o[k]),
      .rd_o       (rd[k])
    );
  end

  // one-hot select: only the cell holding the next token drives nonzero
  always_comb begin
    evict_d = '0;
    for (int k = 0; k < DEPTH; k++) begin
      evict_d = evict_d | rd[k];
    end
  end

  always_ff @(posedge clk_i) begin
    evict_q <= evict_d;
  end

  assign evict_o = evict_q;

endmodule

// File: tb/energy_beat_detector_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// energy_beat_detector_unit_test
// Runs frame energies through the beat detector and checks every result
// against a local running-mean predictor. Covers register defaults and
// readback, history fill and eviction, clamped and shrunk history lengths,
// extreme factor, floor and gap settings, gap count saturation, and random
// phases under random input gaps and output stalls.
// ----------------------------------------------------------------------------
module energy_beat_detector_unit_test;
  import ebd_pkg::*;

  localparam int HMAX           = 64;
  localparam int SETTLE_CYCLES  = 6;     // pipeline drain plus prefetch slack
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct packed {
    logic             beat;
    logic [GAP_W-1:0] gap;
  } beat_res_t;

  logic             clk_i;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [3:0]       paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [E_W-1:0]   energy_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic             beat_o;
  logic [GAP_W-1:0] gap_count_o;

  // predictor state
  logic [31:0]      cfg_regs [4];
  logic [E_W-1:0]   hist_mem [HMAX];
  logic [HMAX-1:0]  slot_written;
  logic [5:0]       slot_ptr;
  logic [6:0]       fill_cnt;
  logic [SUM_W-1:0] run_sum;
  logic [GAP_W-1:0] frames_since;

  beat_res_t pending_beats[$];
  int        mismatches;
  int        stall_left;
  int        quiet_cycles;
  bit        calm;

  energy_beat_detector_unit #(
    .HISTORY_MAX(HMAX)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .energy_i    (energy_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .beat_o      (beat_o),
    .gap_count_o (gap_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    mismatches++;
  endtask

  function automatic logic [31:0] reg_mask(input cfg_reg_e idx);
    case (idx)
      REG_HISTORY_LEN: return (32'd1 << HLEN_W) - 1;
      REG_SENSITIVITY: return (32'd1 << SENS_W) - 1;
      REG_MIN_GAP:     return (32'd1 << GAP_W) - 1;
      default:         return (32'd1 << E_W) - 1;
    endcase
  endfunction

  // Running-mean beat decision for one frame; updates the predictor state.
  function automatic beat_res_t predict_frame(input logic [E_W-1:0] e_in);
    int unsigned len;
    logic [63:0] lhs;
    logic [63:0] rhs;
    beat_res_t   res;
    len = 32'(cfg_regs[REG_HISTORY_LEN][HLEN_W-1:0]);
    if (len < 1) len = 1;
    if (len > HMAX) len = HMAX;
    if (slot_ptr >= len) slot_ptr = '0;
    if (fill_cnt < len) begin
      run_sum  = run_sum + SUM_W'(e_in);
      fill_cnt = fill_cnt + 7'd1;
    end else begin
      run_sum = run_sum - SUM_W'(hist_mem[slot_ptr]) + SUM_W'(e_in);
    end
    hist_mem[slot_ptr]     = e_in;
    slot_written[slot_ptr] = 1'b1;
    slot_ptr = 6'((int'(slot_ptr) + 1) % len);
    res.gap = (frames_since == GAP_SAT) ? GAP_SAT : frames_since + 8'd1;
    lhs = 64'(e_in) * 64'(fill_cnt) * 64'(256);
    rhs = 64'(cfg_regs[REG_SENSITIVITY][SENS_W-1:0]) * 64'(run_sum);
    res.beat = (e_in > cfg_regs[REG_FLOOR_LEVEL][E_W-1:0]) && (lhs > rhs) &&
               (res.gap >= cfg_regs[REG_MIN_GAP][GAP_W-1:0]);
    frames_since = res.beat ? '0 : res.gap;
    return res;
  endfunction

  task automatic apb_access(input logic wr, input cfg_reg_e idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_reg(input cfg_reg_e idx);
    logic [31:0] rd;
    apb_access(1'b0, idx, '0, rd);
    if ((rd & reg_mask(idx)) !== cfg_regs[idx])
      report_mismatch($sformatf("%s reads %0d, expected %0d", idx.name(),
                                rd & reg_mask(idx), cfg_regs[idx]));
  endtask

  task automatic set_reg(input cfg_reg_e idx, input logic [31:0] value);
    logic [31:0] rd;
    apb_access(1'b1, idx, value & reg_mask(idx), rd);
    cfg_regs[idx] = value & reg_mask(idx);
    check_reg(idx);
  endtask

  task automatic send_energy(input logic [E_W-1:0] e_in);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    energy_i   <= e_in;
    do @(posedge clk_i); while (in_stall_o);
    pending_beats.insert(pending_beats.size(), predict_frame(e_in));
  endtask

  // block is idle once every result is back and the pipeline has flushed
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [E_W-1:0] frame_energy(input int base);
    int v;
    case ($urandom_range(0, 19))
      0:       v = 0;
      1:       v = 65535;
      2, 3:    v = $urandom_range(0, 65535);
      4, 5, 6: v = base + $urandom_range(8000, 40000);
      default: v = base + $urandom_range(0, base / 4 + 16);
    endcase
    return (v > 65535) ? 16'hFFFF : E_W'(v);
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_register_defaults();
    check_reg(REG_HISTORY_LEN);
    check_reg(REG_SENSITIVITY);
    check_reg(REG_MIN_GAP);
    check_reg(REG_FLOOR_LEVEL);
  endtask

  // First frames after reset under default settings; stays below 32 items so
  // no slot is evicted before the ring is filled at full length.
  task automatic test_first_frames();
    logic [E_W-1:0] seq [$];
    seq = '{16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd6554,
            16'd6555, 16'd0, 16'd30000, 16'd30000, 16'd0, 16'd45000};
    foreach (seq[i]) send_energy(seq[i]);
    settle();
  endtask

  task automatic test_fill_history();
    set_reg(REG_HISTORY_LEN, HMAX);
    while (slot_written != '1) send_energy(frame_energy(3000));
    settle();
  endtask

  // clamped lengths and a shrink with the pointer past the new length
  task automatic test_length_extremes();
    set_reg(REG_HISTORY_LEN, 0);
    send_energy(16'hFFFF);
    send_energy(16'd0);
    send_energy(16'd100);
    send_energy(16'd100);
    settle();
    set_reg(REG_HISTORY_LEN, 127);
    repeat (3) send_energy(frame_energy(2000));
    settle();
    set_reg(REG_HISTORY_LEN, 1);
    send_energy(16'd40000);
    send_energy(16'd40000);
    settle();
    set_reg(REG_HISTORY_LEN, 64);
    repeat (20) send_energy(frame_energy(1500));
    settle();
    set_reg(REG_HISTORY_LEN, 5);
    repeat (3) send_energy(frame_energy(1500));
    settle();
  endtask

  task automatic test_factor_and_floor_extremes();
    set_reg(REG_SENSITIVITY, 0);
    set_reg(REG_MIN_GAP, 0);
    set_reg(REG_FLOOR_LEVEL, 0);
    send_energy(16'd1);
    send_energy(16'd1);
    send_energy(16'd0);
    send_energy(16'hFFFF);
    settle();
    set_reg(REG_SENSITIVITY, 4095);
    set_reg(REG_MIN_GAP, 1);
    set_reg(REG_FLOOR_LEVEL, 65534);
    send_energy(16'hFFFF);
    send_energy(16'd65534);
    settle();
    set_reg(REG_FLOOR_LEVEL, 65535);
    send_energy(16'hFFFF);
    settle();
  endtask

  // zero frames never beat, so the gap count runs into saturation
  task automatic test_gap_saturation();
    set_reg(REG_SENSITIVITY, 0);
    set_reg(REG_MIN_GAP, 255);
    set_reg(REG_FLOOR_LEVEL, 0);
    repeat (258) send_energy(16'd0);
    send_energy(16'd1);
    send_energy(16'd1);
    settle();
  endtask

  task automatic run_random_phase(input int n_items);
    int base;
    case ($urandom_range(0, 7))
      0:       set_reg(REG_HISTORY_LEN, 0);
      1:       set_reg(REG_HISTORY_LEN, 1);
      2:       set_reg(REG_HISTORY_LEN, 64);
      3:       set_reg(REG_HISTORY_LEN, $urandom_range(65, 127));
      default: set_reg(REG_HISTORY_LEN, $urandom_range(2, 64));
    endcase
    case ($urandom_range(0, 9))
      0:       set_reg(REG_SENSITIVITY, 0);
      1:       set_reg(REG_SENSITIVITY, 4095);
      2:       set_reg(REG_SENSITIVITY, $urandom_range(0, 4095));
      default: set_reg(REG_SENSITIVITY, $urandom_range(256, 640));
    endcase
    case ($urandom_range(0, 9))
      0:       set_reg(REG_MIN_GAP, 0);
      1:       set_reg(REG_MIN_GAP, 255);
      2:       set_reg(REG_MIN_GAP, $urandom_range(0, 255));
      default: set_reg(REG_MIN_GAP, $urandom_range(1, 10));
    endcase
    case ($urandom_range(0, 9))
      0:       set_reg(REG_FLOOR_LEVEL, 0);
      1:       set_reg(REG_FLOOR_LEVEL, 65535);
      2:       set_reg(REG_FLOOR_LEVEL, $urandom_range(0, 65535));
      default: set_reg(REG_FLOOR_LEVEL, $urandom_range(0, 8000));
    endcase
    base = $urandom_range(0, 12000);
    repeat (n_items) send_energy(frame_energy(base));
    settle();
  endtask

  // ---------------------------------------------------------------- result side

  always @(posedge clk_i) begin
    if (!rst_ni || calm) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 5);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    beat_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_beats.size() == 0) begin
        report_mismatch("result item with nothing expected");
      end else begin
        want = pending_beats[0];
        pending_beats.delete(0);
        if (beat_o !== want.beat)
          report_mismatch($sformatf("beat %b, expected %b", beat_o, want.beat));
        if (gap_count_o !== want.gap)
          report_mismatch($sformatf("gap_count %0d, expected %0d", gap_count_o, want.gap));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_ni      <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    in_valid_i  <= 1'b0;
    energy_i    <= '0;
    out_stall_i <= 1'b0;
    mismatches   = 0;
    stall_left   = 0;
    quiet_cycles = 0;
    calm         = 1'b0;
    cfg_regs[REG_HISTORY_LEN] = 32'(HLEN_RST);
    cfg_regs[REG_SENSITIVITY] = 32'(SENS_RST);
    cfg_regs[REG_MIN_GAP]     = 32'(MINGAP_RST);
    cfg_regs[REG_FLOOR_LEVEL] = 32'(FLOOR_RST);
    foreach (hist_mem[i]) hist_mem[i] = '0;
    slot_written = '0;
    slot_ptr     = '0;
    fill_cnt     = '0;
    run_sum      = '0;
    frames_since = GAP_SAT;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_defaults();
    test_first_frames();
    test_fill_history();
    test_length_extremes();
    test_factor_and_floor_extremes();
    test_gap_saturation();
    repeat (4) run_random_phase(35);
    calm = 1'b1;
    run_random_phase(50);

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: energy_beat_detector_unit.f
sv/ebd_pkg.sv
sv/ebd_cell.sv
sv/ebd_ring.sv
sv/energy_beat_detector_unit.sv
tb/energy_beat_detector_unit_test.sv
